FILE: rtl/bpa_pkg.sv
// Shared constants, interface widths and state types of the bitmap page allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  // Default sizing; page size and word width are powers of two
  localparam int unsigned MAX_PAGES_DEF  = 131072;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 64;

  // Field and port widths
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned CNT_OUT_W  = 18;
  localparam int unsigned S_TDATA_W  = 64;
  localparam int unsigned S_TUSER_W  = 2;
  localparam int unsigned M_TDATA_W  = 232;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 64;

  // Register select on paddr[3]
  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_OWN   = 2'd2,
    ACT_INIT  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_GRANT,
    ST_LOC1,
    ST_LOC2,
    ST_FREE_CHK,
    ST_INIT1,
    ST_INIT2,
    ST_INIT3,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/bpa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/bitmap_page_allocator_top.sv
// Next-fit physical page allocator over a usage bitmap held in one RAM.
//
// Input stream: s_axis_tuser carries the action (allocate, free, ownership
// query, initialize), s_axis_tdata the page address. Each accepted item gives
// exactly one result item on the master stream: ok, granted address, free and
// total page counts and the aligned managed range.
// Configuration: APB registers for the raw region start (0x0) and end (0x8).
// Write them while the block is idle, then send an initialize item.
// Items are taken one at a time. States from accept to the result register:
//   allocate  SCAN, one word read per cycle from the bitmap RAM, starting at
//             the word of the search hint, then GRANT and RESP
//   free      LOC1, LOC2, FREE_CHK for a valid address, RESP; ownership query LOC1, LOC2, RESP
//   initialize INIT1, INIT2, INIT3, CLEAR over the bitmap words that held the previous range, RESP
// A failing allocate (no free page) goes straight to RESP.
// After reset the bitmap RAM is cleared one word per cycle, all
// ceil(MAX_PAGES / WORD_BITS) words, with s_axis_tready low; APB writes
// are taken during that pass. The result sits in an output register, so the
// next item is accepted while it waits; a stalled receiver holds the block
// only when a second result is ready to be loaded.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator_top #(
  parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned WORD_BITS  = bpa_pkg::WORD_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input items
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [63:0] page_address
  input  wire logic [bpa_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] action
  input  wire logic [bpa_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // Result items
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] ok, [64:1] granted_address, [82:65] free_count, [100:83] total_count,
  // [164:101] managed_base, [228:165] managed_limit, [231:229] zero
  output logic      [bpa_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // Configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bpa_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [bpa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [bpa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  import bpa_pkg::*;

  localparam int unsigned WORDS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WBS        = $clog2(WORD_BITS);
  localparam int unsigned PG_W       = WA_W + WBS;
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned MW         = ((PG_W > CNT_W) ? PG_W : CNT_W) + 1;
  localparam int unsigned WC_W       = $clog2(WORDS + 1);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned QH         = PAGE_SHIFT + PG_W;

  localparam logic [ADDR_W-1:0]    PMASK     = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0]    PAGE_STEP = ADDR_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0]    MAX_N     = ADDR_W'(MAX_PAGES);
  localparam logic [ADDR_W-1:0]    MAX_SPAN  = ADDR_W'(MAX_PAGES) << PAGE_SHIFT;
  localparam logic [WBS-1:0]       TOP_BIT   = WBS'(WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};

  // Control state
  state_e              state_q, state_d;
  action_e             act_q, act_d;
  logic                out_valid_q, out_valid_d;
  logic [WC_W-1:0]     clr_q, clr_d;
  logic [WC_W-1:0]     clr_cnt_q, clr_cnt_d;

  // Allocator state
  logic [ADDR_W-1:0]   cfg_first_q, cfg_last_q;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [ADDR_W-1:0]   limit_q, limit_d;
  logic [CNT_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [PG_W-1:0]     hint_q, hint_d;
  logic [PG_W-1:0]     last_pg_q, last_pg_d;

  // Per-item working registers
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [ADDR_W-1:0]   delta_q, delta_d;
  logic                bad_q, bad_d;
  logic [ADDR_W-1:0]   start_q, start_d;
  logic [ADDR_W-1:0]   end_q, end_d;
  logic [ADDR_W-1:0]   cap_end_q, cap_end_d;
  logic [ADDR_W-1:0]   diff_q, diff_d;
  logic                ovf_q, ovf_d;
  logic                empty_q, empty_d;
  logic                ok_q, ok_d;
  logic [ADDR_W-1:0]   grant_q, grant_d;
  logic [PG_W-1:0]     cur_q, cur_d;
  logic [WA_W-1:0]     scan_wd_q, scan_wd_d;
  logic                first_q, first_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  // Bitmap RAM ports
  logic                 mem_we, mem_re;
  logic [WA_W-1:0]      mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  // Shared conditions
  logic                 in_acc;
  logic                 res_load;
  logic                 alloc_none;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, open_vec, pick_mask;
  logic [WBS-1:0]       pick_bit;
  logic                 found;
  logic [WA_W-1:0]      last_wd;
  logic [PG_W-1:0]      loc_idx;
  logic                 loc_ok;
  logic                 page_used;
  logic                 clr_done;
  logic                 cfg_we;
  logic [ADDR_W:0]      start_sum;
  logic                 rem_nz;
  logic [ADDR_W-1:0]    n_full;
  logic                 clamp;
  logic [CNT_W:0]       used_words;
  logic [CNT_W+CNT_OUT_W-1:0] free_ext, total_ext;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign res_load      = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign alloc_none    = (free_q == '0) || (total_q == '0);
  assign clr_done      = (clr_q == clr_cnt_q);

  // Scan one bitmap word: clear bits at or above the hint on the first visit,
  // never past the last managed page
  assign last_wd  = last_pg_q[PG_W-1:WBS];
  assign lo_mask  = first_q ? (ONES << hint_q[WBS-1:0]) : ONES;
  assign hi_mask  = (scan_wd_q == last_wd) ? (ONES >> (TOP_BIT - last_pg_q[WBS-1:0])) : ONES;
  assign open_vec = ~mem_rdata & lo_mask & hi_mask;
  assign found    = |open_vec;

  // Lowest open bit
  always_comb begin
    pick_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (open_vec[i]) begin
        pick_bit = WBS'(i);
      end
    end
  end

  assign pick_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pick_bit;

  // Address check: aligned from base, page index inside the managed count
  assign loc_idx   = delta_q[PAGE_SHIFT +: PG_W];
  assign loc_ok    = !bad_q && ((delta_q & PMASK) == '0) && (delta_q[ADDR_W-1:QH] == '0) &&
                     (MW'(loc_idx) < MW'(total_q));
  assign page_used = mem_rdata[cur_q[WBS-1:0]];

  // Init arithmetic
  assign rem_nz     = |(cfg_first_q & PMASK);
  assign start_sum  = {1'b0, cfg_first_q & ~PMASK} + {1'b0, (rem_nz ? PAGE_STEP : '0)};
  assign n_full     = diff_q >> PAGE_SHIFT;
  assign clamp      = (n_full > MAX_N);
  assign used_words = ((CNT_W+1)'(total_q) + (CNT_W+1)'(WORD_BITS - 1)) >> WBS;

  // Count fields of the result
  assign free_ext  = {{CNT_OUT_W{1'b0}}, free_q};
  assign total_ext = {{CNT_OUT_W{1'b0}}, total_q};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_done) begin
          state_d = (act_q == ACT_INIT) ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(s_axis_tuser))
            ACT_ALLOC: state_d = alloc_none ? ST_RESP : ST_SCAN;
            ACT_FREE:  state_d = ST_LOC1;
            ACT_OWN:   state_d = ST_LOC1;
            ACT_INIT:  state_d = ST_INIT1;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN:     state_d = found ? ST_GRANT : ST_SCAN;
      ST_GRANT:    state_d = ST_RESP;
      ST_LOC1:     state_d = ST_LOC2;
      ST_LOC2:     state_d = (act_q == ACT_FREE && loc_ok) ? ST_FREE_CHK : ST_RESP;
      ST_FREE_CHK: state_d = ST_RESP;
      ST_INIT1:    state_d = ST_INIT2;
      ST_INIT2:    state_d = ST_INIT3;
      ST_INIT3:    state_d = ST_CLEAR;
      ST_RESP:     state_d = res_load ? ST_IDLE : ST_RESP;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and bitmap access
  always_comb begin
    act_d       = act_q;
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    base_d      = base_q;
    limit_d     = limit_q;
    total_d     = total_q;
    free_d      = free_q;
    hint_d      = hint_q;
    last_pg_d   = last_pg_q;
    addr_d      = addr_q;
    delta_d     = delta_q;
    bad_d       = bad_q;
    start_d     = start_q;
    end_d       = end_q;
    cap_end_d   = cap_end_q;
    diff_d      = diff_q;
    ovf_d       = ovf_q;
    empty_d     = empty_q;
    ok_d        = ok_q;
    grant_d     = grant_q;
    cur_d       = cur_q;
    scan_wd_d   = scan_wd_q;
    first_d     = first_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_waddr   = clr_q[WA_W-1:0];
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = hint_q[PG_W-1:WBS];

    // Drop the result once taken
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Zero one bitmap word per cycle
        if (!clr_done) begin
          mem_we = 1'b1;
          clr_d  = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          act_d   = action_e'(s_axis_tuser);
          addr_d  = s_axis_tdata;
          ok_d    = 1'b0;
          grant_d = '0;
          case (action_e'(s_axis_tuser))
            ACT_ALLOC: begin
              // Read the hint's word, first visit masks bits below the hint
              mem_re    = !alloc_none;
              scan_wd_d = hint_q[PG_W-1:WBS];
              first_d   = 1'b1;
            end
            ACT_INIT: begin
              // Sweep only the words the previous range could have touched
              clr_d     = '0;
              clr_cnt_d = WC_W'(used_words);
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (found) begin
          mem_we    = 1'b1;
          mem_waddr = scan_wd_q;
          mem_wdata = mem_rdata | pick_mask;
          cur_d     = {scan_wd_q, pick_bit};
          free_d    = free_q - 1'b1;
          hint_d    = ({scan_wd_q, pick_bit} == last_pg_q) ? '0 : {scan_wd_q, pick_bit} + 1'b1;
          ok_d      = 1'b1;
        end else begin
          // Advance to the next word, wrapping inside the managed pages
          scan_wd_d = (scan_wd_q == last_wd) ? '0 : scan_wd_q + 1'b1;
          first_d   = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = (scan_wd_q == last_wd) ? '0 : scan_wd_q + 1'b1;
        end
      end
      ST_GRANT: begin
        grant_d = base_q + (ADDR_W'(cur_q) << PAGE_SHIFT);
      end
      ST_LOC1: begin
        bad_d   = (addr_q == '0) || (addr_q < base_q) || (addr_q >= limit_q);
        delta_d = addr_q - base_q;
      end
      ST_LOC2: begin
        cur_d = loc_idx;
        if (act_q == ACT_OWN) begin
          ok_d = loc_ok;
        end else if (loc_ok) begin
          mem_re    = 1'b1;
          mem_raddr = loc_idx[PG_W-1:WBS];
        end
      end
      ST_FREE_CHK: begin
        // Release only a page that is held
        if (page_used) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q[PG_W-1:WBS];
          mem_wdata = mem_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << cur_q[WBS-1:0]);
          free_d    = free_q + 1'b1;
          ok_d      = 1'b1;
          if (cur_q < hint_q || free_q == '0) begin
            hint_d = cur_q;
          end
        end
      end
      ST_INIT1: begin
        // Round start up and end down to whole pages
        start_d = start_sum[ADDR_W-1:0];
        ovf_d   = start_sum[ADDR_W];
        end_d   = cfg_last_q & ~PMASK;
      end
      ST_INIT2: begin
        empty_d   = ovf_q || (end_q <= start_q);
        diff_d    = end_q - start_q;
        cap_end_d = start_q + MAX_SPAN;
      end
      ST_INIT3: begin
        // Commit the new range, clamped to the page limit
        hint_d = '0;
        ok_d   = 1'b1;
        if (empty_q) begin
          base_d    = '0;
          limit_d   = '0;
          total_d   = '0;
          free_d    = '0;
          last_pg_d = '0;
        end else begin
          base_d    = start_q;
          limit_d   = clamp ? cap_end_q : end_q;
          total_d   = clamp ? CNT_W'(MAX_PAGES) : n_full[CNT_W-1:0];
          free_d    = clamp ? CNT_W'(MAX_PAGES) : n_full[CNT_W-1:0];
          last_pg_d = clamp ? PG_W'(MAX_PAGES - 1) : n_full[PG_W-1:0] - 1'b1;
        end
      end
      ST_RESP: begin
        if (res_load) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, limit_q, base_q, total_ext[CNT_OUT_W-1:0],
                         free_ext[CNT_OUT_W-1:0], grant_q, ok_q};
        end
      end
      default: ;
    endcase
  end

  // Configuration registers
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[3])
      REG_FIRST: prdata = cfg_first_q;
      REG_LAST:  prdata = cfg_last_q;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_first_q <= '0;
      cfg_last_q  <= '0;
    end else if (cfg_we) begin
      if (paddr[3] == REG_LAST) begin
        cfg_last_q <= pwdata;
      end else begin
        cfg_first_q <= pwdata;
      end
    end
  end

  // Control and allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      act_q       <= ACT_ALLOC;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      clr_cnt_q   <= WC_W'(WORDS);
      base_q      <= '0;
      limit_q     <= '0;
      total_q     <= '0;
      free_q      <= '0;
      hint_q      <= '0;
      last_pg_q   <= '0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      base_q      <= base_d;
      limit_q     <= limit_d;
      total_q     <= total_d;
      free_q      <= free_d;
      hint_q      <= hint_d;
      last_pg_q   <= last_pg_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    delta_q    <= delta_d;
    bad_q      <= bad_d;
    start_q    <= start_d;
    end_q      <= end_d;
    cap_end_q  <= cap_end_d;
    diff_q     <= diff_d;
    ovf_q      <= ovf_d;
    empty_q    <= empty_d;
    ok_q       <= ok_d;
    grant_q    <= grant_d;
    cur_q      <= cur_d;
    scan_wd_q  <= scan_wd_d;
    first_q    <= first_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the bitmap page allocator: directed and random item streams.
`timescale 1ns / 1ps

module tb_top;
  import bpa_pkg::*;

  localparam int unsigned NPAGES       = MAX_PAGES_DEF;
  localparam int unsigned PGSZ         = PAGE_BYTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned CYCLE_LIMIT  = 10000000;
  localparam int unsigned DRAIN_CYCLES = 2200;

  typedef struct {
    action_e     act;
    logic [63:0] addr;
  } page_req_t;

  typedef struct {
    logic        ok;
    logic [63:0] granted;
    logic [17:0] free_cnt;
    logic [17:0] total_cnt;
    logic [63:0] first_page;
    logic [63:0] limit_addr;
  } page_resp_t;

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_W-1:0]    s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0]    s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  logic                    psel          = 1'b0;
  logic                    penable       = 1'b0;
  logic                    pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr         = '0;
  logic [APB_DATA_W-1:0]   pwdata        = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  bitmap_page_allocator_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Allocator state as the testbench tracks it
  bit          page_used [NPAGES];
  logic [63:0] cfg_first = '0;
  logic [63:0] cfg_last  = '0;
  logic [63:0] mgd_base  = '0;
  logic [63:0] mgd_limit = '0;
  int unsigned mgd_total = 0;
  int unsigned mgd_free  = 0;
  int unsigned next_hint = 0;

  page_req_t   request_queue[$];
  page_resp_t  awaited_results[$];
  page_req_t   cur_req;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycle_count);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) flag_mismatch(what, got, want);
  endtask

  // Map an address to a managed page index; zero, outside or misaligned fail
  function automatic bit page_index_of(logic [63:0] addr, output int unsigned idx);
    logic [63:0] delta;
    idx = 0;
    if (addr == '0 || addr < mgd_base || addr >= mgd_limit) return 1'b0;
    delta = addr - mgd_base;
    if (delta % PGSZ != 0) return 1'b0;
    if (delta / PGSZ >= mgd_total) return 1'b0;
    idx = int'(delta / PGSZ);
    return 1'b1;
  endfunction

  // Align the configured range, clamp it and mark every page free
  function automatic void reload_range();
    logic [63:0] rem;
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] npg;
    bit          ovf;
    rem   = cfg_first % PGSZ;
    start = cfg_first - rem;
    stop  = cfg_last - (cfg_last % PGSZ);
    ovf   = 1'b0;
    if (rem != 0) begin
      if (start > 64'hFFFF_FFFF_FFFF_FFFF - PGSZ) ovf = 1'b1;
      else start = start + PGSZ;
    end
    foreach (page_used[i]) page_used[i] = 1'b0;
    mgd_base  = '0;
    mgd_limit = '0;
    mgd_total = 0;
    mgd_free  = 0;
    next_hint = 0;
    if (ovf || stop <= start) return;
    npg = (stop - start) / PGSZ;
    if (npg > NPAGES) begin
      npg  = NPAGES;
      stop = start + npg * PGSZ;
    end
    mgd_base  = start;
    mgd_limit = stop;
    mgd_total = int'(npg);
    mgd_free  = int'(npg);
  endfunction

  // Apply one request to the tracked state and return the result it gives
  function automatic page_resp_t serve_request(page_req_t req);
    page_resp_t  r;
    int unsigned cur;
    int unsigned idx;
    r.ok      = 1'b0;
    r.granted = '0;
    case (req.act)
      ACT_ALLOC: begin
        if (mgd_free != 0 && mgd_total != 0) begin
          cur = next_hint % mgd_total;
          for (int unsigned s = 0; s < mgd_total; s++) begin
            if (!page_used[cur]) begin
              page_used[cur] = 1'b1;
              mgd_free--;
              next_hint = (cur + 1) % mgd_total;
              r.granted = mgd_base + 64'(cur) * PGSZ;
              r.ok      = 1'b1;
              break;
            end
            cur++;
            if (cur >= mgd_total) cur = 0;
          end
        end
      end
      ACT_FREE: begin
        if (page_index_of(req.addr, idx) && page_used[idx]) begin
          page_used[idx] = 1'b0;
          mgd_free++;
          if (idx < next_hint || mgd_free == 1) next_hint = idx;
          r.ok = 1'b1;
        end
      end
      ACT_OWN: begin
        r.ok = page_index_of(req.addr, idx);
      end
      default: begin
        reload_range();
        r.ok = 1'b1;
      end
    endcase
    r.free_cnt   = 18'(mgd_free);
    r.total_cnt  = 18'(mgd_total);
    r.first_page = mgd_base;
    r.limit_addr = mgd_limit;
    return r;
  endfunction

  // Sender: record accepted items, present the next one in bursts with gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(serve_request(cur_req));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          cur_req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cur_req.addr;
          s_axis_tuser  <= cur_req.act;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            // keep a stretch of every window free of gaps
            if (cycle_count % 3000 < 1000 || $urandom_range(3, 0) == 0) gap_left = 0;
            else gap_left = $urandom_range(12, 1);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on one of four patterns, chosen in turn from cycle_count
  always @(posedge clk_i) begin
    case ((cycle_count / 400) % 4)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(1, 0) == 1);
      2:       m_axis_tready <= ($urandom_range(7, 0) == 0);
      default: m_axis_tready <= (cycle_count % 5 != 0);
    endcase
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    page_resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with none expected", m_axis_tdata[63:0], '0);
      end else begin
        want = awaited_results.pop_front();
        check_field("ok", m_axis_tdata[0], want.ok);
        check_field("granted_address", m_axis_tdata[64:1], want.granted);
        check_field("free_count", m_axis_tdata[82:65], want.free_cnt);
        check_field("total_count", m_axis_tdata[100:83], want.total_cnt);
        check_field("managed_base", m_axis_tdata[164:101], want.first_page);
        check_field("managed_limit", m_axis_tdata[228:165], want.limit_addr);
      end
    end
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] any_word();
    return {$urandom, $urandom};
  endfunction

  // Pick a free or query address: mostly managed pages, some bad ones
  function automatic logic [63:0] pick_address(logic [63:0] base, int unsigned npg);
    int unsigned roll;
    int unsigned span;
    logic [63:0] page;
    roll = $urandom_range(99, 0);
    if (npg < 256 || $urandom_range(3, 0) == 0) span = npg + 1;
    else span = 256;
    page = base + 64'($urandom_range(span, 0)) * PGSZ;
    if (roll < 70) return page;
    if (roll < 80) return page + 64'($urandom_range(PGSZ - 1, 1));
    if (roll < 90) return any_word();
    if (roll < 95) return '0;
    return base - PGSZ;
  endfunction

  task automatic post(action_e act, logic [63:0] addr);
    page_req_t req;
    req.act  = act;
    req.addr = addr;
    request_queue.push_back(req);
  endtask

  // Hold until no item is queued, in flight or awaiting its result; look
  // at the falling edge so every rising-edge update has settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_queue.size() != 0 || s_axis_tvalid || awaited_results.size() != 0);
  endtask

  task automatic write_region(logic sel, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_LAST) cfg_last = value;
    else cfg_first = value;
  endtask

  initial begin
    logic [63:0] base;
    logic [63:0] raw_first;
    logic [63:0] raw_last;
    int unsigned npg;
    int unsigned roll;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Nothing managed yet: allocate fails, empty init
    post(ACT_ALLOC, '0);
    post(ACT_OWN, 64'h1000);
    post(ACT_INIT, '0);
    post(ACT_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_idle();

    // Four pages from address zero: exhaust, double free, bad addresses
    write_region(REG_FIRST, '0);
    write_region(REG_LAST, 64'h4000 + 64'd123);
    post(ACT_INIT, '0);
    repeat (5) post(ACT_ALLOC, '0);
    post(ACT_FREE, '0);
    post(ACT_FREE, 64'h2000);
    post(ACT_FREE, 64'h2000);
    post(ACT_FREE, 64'h2001);
    post(ACT_FREE, 64'h4000);
    post(ACT_OWN, 64'h1000);
    post(ACT_OWN, 64'hFFFF_FFFF_FFFF_FFFF);
    post(ACT_FREE, 64'h3000);
    post(ACT_ALLOC, '0);
    wait_idle();

    // Start rounding past the top of the address space
    write_region(REG_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
    write_region(REG_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
    post(ACT_INIT, '0);
    post(ACT_OWN, 64'hFFFF_FFFF_FFFF_F000);
    wait_idle();

    // Range just under the top of the address space
    write_region(REG_FIRST, 64'hFFFF_FFFF_FFFF_0001);
    post(ACT_INIT, '0);
    post(ACT_ALLOC, '0);
    post(ACT_OWN, 64'hFFFF_FFFF_FFFF_1000);
    wait_idle();

    // Random phases, each with its own region
    for (int ph = 0; ph < PHASES; ph++) begin
      base = any_word() & 64'h7FFF_FFFF_FFFF_F000;
      if ($urandom_range(9, 0) < 6) npg = $urandom_range(64, 1);
      else npg = $urandom_range(400, 65);
      if (ph == 0) base = '0;
      if (ph == 6) base = 64'hFFFF_FFFF_FFFF_F000 - 64'(npg) * PGSZ;
      raw_first = base;
      if (base != '0 && $urandom_range(1, 0) == 1)
        raw_first = base - 64'($urandom_range(PGSZ - 1, 1));
      raw_last = base + 64'(npg) * PGSZ + 64'($urandom_range(PGSZ - 1, 0));
      if (ph == 3) begin
        // whole bitmap in use, clamped from an open-ended range
        npg      = NPAGES;
        raw_last = 64'hFFFF_FFFF_FFFF_FFFF;
      end
      if (ph == 6) raw_last = 64'hFFFF_FFFF_FFFF_FFFF;
      if (ph == 8) raw_last = base - 64'($urandom_range(3, 0) * PGSZ);
      write_region(REG_FIRST, raw_first);
      write_region(REG_LAST, raw_last);
      post(ACT_INIT, any_word());
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        roll = $urandom_range(99, 0);
        if (roll < 42) post(ACT_ALLOC, any_word());
        else if (roll < 77) post(ACT_FREE, pick_address(base, npg));
        else if (roll < 96) post(ACT_OWN, pick_address(base, npg));
        else post(ACT_INIT, any_word());
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bitmap_page_allocator_top.sv
verif/tb_top.sv
